### rtl/tclc_pkg.sv
package tclc_pkg;

  // result of each pipeline step is carried with these flags
  typedef struct packed {
    logic valid;
    logic oor;
  } div_flags_t;

  typedef enum logic [1:0] {
    SEG_POW  = 2'd0,
    SEG_MID  = 2'd1,
    SEG_HIGH = 2'd2,
    SEG_TAIL = 2'd3
  } seg_t;

  localparam int CNT_W = 16;
  localparam int ACC_W = 44;

  // coefficients in Q16, rounded half up
  localparam logic [11:0] COEF_A1 = 12'((3040 * 65536 + 50000) / 100000);
  localparam logic [11:0] COEF_B1 = 12'((6200 * 65536 + 50000) / 100000);
  localparam logic [10:0] COEF_A2 = 11'((2240 * 65536 + 50000) / 100000);
  localparam logic [10:0] COEF_B2 = 11'((3100 * 65536 + 50000) / 100000);
  localparam logic [10:0] COEF_A3 = 11'((1280 * 65536 + 50000) / 100000);
  localparam logic [10:0] COEF_B3 = 11'((1530 * 65536 + 50000) / 100000);
  localparam logic [10:0] COEF_A4 = 11'((146 * 65536 + 50000) / 100000);
  localparam logic [10:0] COEF_B4 = 11'((112 * 65536 + 50000) / 100000);

  // largest v with v <= 2^16 * (k / 2d)^1.4, exact integer search
  // checks v^5 * (2d)^7 <= 2^80 * k^7
  function automatic logic [15:0] pow_entry(input int unsigned k, input int unsigned d);
    logic [191:0] lhs;
    logic [191:0] rhs;
    logic [16:0]  lo;
    logic [16:0]  hi;
    logic [16:0]  mid;
    lo = '0;
    hi = 17'd65536;
    for (int it = 0; it < 18; it++) begin
      if (lo < hi) begin
        mid = 17'((18'(lo) + 18'(hi) + 18'd1) >> 1);
        lhs = 192'd1;
        rhs = 192'd1 << 80;
        for (int j = 0; j < 5; j++) begin
          lhs = lhs * 192'(mid);
        end
        for (int j = 0; j < 7; j++) begin
          lhs = lhs * 192'(2 * d);
          rhs = rhs * 192'(k);
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 17'd1;
        end
      end
    end
    return lo[15:0];
  endfunction

endpackage

### rtl/tclc_div.sv
module tclc_div #(
  parameter int RATIO_FRAC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic [tclc_pkg::CNT_W-1:0]       in_ch0,
  input  logic [tclc_pkg::CNT_W-1:0]       in_ch1,
  output tclc_pkg::div_flags_t             out_flags,
  output logic [RATIO_FRAC_BITS:0]         out_ratio,
  output logic [tclc_pkg::CNT_W-1:0]       out_ch0,
  output logic [tclc_pkg::CNT_W-1:0]       out_ch1
);

  localparam int QW = RATIO_FRAC_BITS + 1;
  localparam int NS = QW;
  localparam int CW = tclc_pkg::CNT_W;

  // one quotient bit per stage, msb first; ratio >= 2 is flagged up front
  logic [CW:0]   rem_r   [NS];
  logic [QW-1:0] q_r     [NS];
  logic [CW-1:0] c0_r    [NS];
  logic [CW-1:0] c1_r    [NS];
  logic          v_r     [NS];
  logic          oor_r   [NS];

  logic [CW:0]   rem_in  [NS];
  logic [QW-1:0] q_in    [NS];
  logic [CW-1:0] c0_in   [NS];
  logic [CW-1:0] c1_in   [NS];
  logic [CW:0]   rem_nxt [NS];
  logic [QW-1:0] q_nxt   [NS];
  logic          oor_nxt;

  always_comb begin
    logic [CW:0] diff;
    logic        ge;
    rem_in[0] = {1'b0, in_ch1};
    q_in[0]   = '0;
    c0_in[0]  = in_ch0;
    c1_in[0]  = in_ch1;
    for (int j = 1; j < NS; j++) begin
      rem_in[j] = rem_r[j-1];
      q_in[j]   = q_r[j-1];
      c0_in[j]  = c0_r[j-1];
      c1_in[j]  = c1_r[j-1];
    end
    for (int j = 0; j < NS; j++) begin
      ge         = rem_in[j] >= {1'b0, c0_in[j]};
      diff       = rem_in[j] - {1'b0, c0_in[j]};
      rem_nxt[j] = ge ? {diff[CW-1:0], 1'b0} : {rem_in[j][CW-1:0], 1'b0};
      q_nxt[j]   = {q_in[j][QW-2:0], ge};
    end
    oor_nxt = (in_ch0 == '0) || ({1'b0, in_ch1} >= {in_ch0, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NS; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int j = 1; j < NS; j++) begin
        v_r[j] <= v_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor_r[0] <= oor_nxt;
      for (int j = 1; j < NS; j++) begin
        oor_r[j] <= oor_r[j-1];
      end
      for (int j = 0; j < NS; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        c0_r[j]  <= c0_in[j];
        c1_r[j]  <= c1_in[j];
      end
    end
  end

  assign out_flags.valid = v_r[NS-1];
  assign out_flags.oor   = oor_r[NS-1];
  assign out_ratio       = q_r[NS-1];
  assign out_ch0         = c0_r[NS-1];
  assign out_ch1         = c1_r[NS-1];

endmodule

### rtl/two_channel_lux_calc.sv
// illuminance from a broadband and an infrared sensor count
// input request: in_valid with in_broadband_count and in_infrared_count, taken
// at a clock edge where in_valid is high and in_stall is low
// result request: out_valid with out_lux_value (lux in units of 2^-LUX_FRAC_BITS),
// out_was_clamped and out_ratio_out_of_range, taken when out_stall is low
// every request gives exactly one result, in order
// path from accept to out_valid: RATIO_FRAC_BITS + 1 divider stages, one
// quotient bit each, then segment select, table read and coefficient
// products, segment combine, final product, and rounding with the 1000 lux
// clamp into the output register
// throughput: one request per clock unless out_stall holds a result; all stages advance together
// when out_stall holds a waiting result, the whole pipeline freezes and in_stall
// is raised in the same cycle; nothing is dropped or repeated
// reset (rst_n low, synchronous) empties the pipeline; the power table is
// a constant and needs no fill time
module two_channel_lux_calc #(
  parameter int RATIO_FRAC_BITS = 12,
  parameter int LUX_FRAC_BITS   = 8,
  parameter int POW_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_broadband_count,
  input  logic [15:0] in_infrared_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [17:0] out_lux_value,
  output logic        out_was_clamped,
  output logic        out_ratio_out_of_range
);

  localparam int CW    = tclc_pkg::CNT_W;
  localparam int AW    = tclc_pkg::ACC_W;
  localparam int QW    = RATIO_FRAC_BITS + 1;
  localparam int DW    = $clog2(2 * POW_TABLE_DEPTH + 1);
  localparam int PW    = QW + DW;
  localparam int IW    = $clog2(POW_TABLE_DEPTH + 1);
  localparam int SH    = 32 - LUX_FRAC_BITS;

  localparam logic [QW-1:0] THR_HALF = QW'(1 << (RATIO_FRAC_BITS - 1));
  localparam logic [QW-1:0] THR_61   = QW'(((61 << RATIO_FRAC_BITS) + 50) / 100);
  localparam logic [QW-1:0] THR_80   = QW'(((80 << RATIO_FRAC_BITS) + 50) / 100);
  localparam logic [QW-1:0] THR_130  = QW'(((130 << RATIO_FRAC_BITS) + 50) / 100);

  localparam logic [AW:0] RND_HALF  = (AW+1)'(1) << (SH - 1);
  localparam logic [AW:0] LUX_LIMIT = (AW+1)'(1000) << LUX_FRAC_BITS;
  localparam logic [AW:0] LUX_CLAMP = (AW+1)'(999) << LUX_FRAC_BITS;
  localparam logic [27:0] SEG1_BASE = 28'(tclc_pkg::COEF_A1) << 16;

  logic adv;

  // power table, entry k = 2^16 * (k / 2D)^1.4
  logic [15:0] pow_rom [POW_TABLE_DEPTH+1];

  for (genvar k = 0; k <= POW_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [15:0] ENTRY = tclc_pkg::pow_entry(k, POW_TABLE_DEPTH);
    assign pow_rom[k] = ENTRY;
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ratio
  tclc_pkg::div_flags_t div_flags;
  logic [QW-1:0]        div_ratio;
  logic [CW-1:0]        div_ch0;
  logic [CW-1:0]        div_ch1;

  tclc_div #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_ch0   (in_broadband_count),
    .in_ch1   (in_infrared_count),
    .out_flags(div_flags),
    .out_ratio(div_ratio),
    .out_ch0  (div_ch0),
    .out_ch1  (div_ch1)
  );

  // segment select and table index
  tclc_pkg::div_flags_t sa_flags_r;
  tclc_pkg::seg_t       sa_seg_r;
  tclc_pkg::seg_t       sa_seg_nxt;
  logic [IW-1:0]        sa_idx_r;
  logic [IW-1:0]        sa_idx_nxt;
  logic [10:0]          sa_ca_r;
  logic [10:0]          sa_cb_r;
  logic [10:0]          sa_ca_nxt;
  logic [10:0]          sa_cb_nxt;
  logic [CW-1:0]        sa_ch0_r;
  logic [CW-1:0]        sa_ch1_r;
  logic                 sa_oor_nxt;
  logic [PW-1:0]        idx_prod;
  logic [PW-1:0]        idx_full;

  always_comb begin
    idx_prod   = PW'(div_ratio) * PW'(2 * POW_TABLE_DEPTH);
    idx_full   = idx_prod >> RATIO_FRAC_BITS;
    sa_idx_nxt = (idx_full > PW'(POW_TABLE_DEPTH)) ? IW'(POW_TABLE_DEPTH) : idx_full[IW-1:0];
    sa_oor_nxt = div_flags.oor;
    if (div_ratio <= THR_HALF) begin
      sa_seg_nxt = tclc_pkg::SEG_POW;
    end else if (div_ratio <= THR_61) begin
      sa_seg_nxt = tclc_pkg::SEG_MID;
    end else if (div_ratio <= THR_80) begin
      sa_seg_nxt = tclc_pkg::SEG_HIGH;
    end else begin
      sa_seg_nxt = tclc_pkg::SEG_TAIL;
      if (div_ratio > THR_130) begin
        sa_oor_nxt = 1'b1;
      end
    end
    case (sa_seg_nxt)
      tclc_pkg::SEG_MID: begin
        sa_ca_nxt = tclc_pkg::COEF_A2;
        sa_cb_nxt = tclc_pkg::COEF_B2;
      end
      tclc_pkg::SEG_HIGH: begin
        sa_ca_nxt = tclc_pkg::COEF_A3;
        sa_cb_nxt = tclc_pkg::COEF_B3;
      end
      default: begin
        sa_ca_nxt = tclc_pkg::COEF_A4;
        sa_cb_nxt = tclc_pkg::COEF_B4;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_flags_r.valid <= 1'b0;
    end else if (adv) begin
      sa_flags_r.valid <= div_flags.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_flags_r.oor <= sa_oor_nxt;
      sa_seg_r       <= sa_seg_nxt;
      sa_idx_r       <= sa_idx_nxt;
      sa_ca_r        <= sa_ca_nxt;
      sa_cb_r        <= sa_cb_nxt;
      sa_ch0_r       <= div_ch0;
      sa_ch1_r       <= div_ch1;
    end
  end

  // table read and linear products
  tclc_pkg::div_flags_t sb_flags_r;
  tclc_pkg::seg_t       sb_seg_r;
  logic [15:0]          sb_rom_r;
  logic [26:0]          sb_p0_r;
  logic [26:0]          sb_p1_r;
  logic [26:0]          sb_p0_nxt;
  logic [26:0]          sb_p1_nxt;
  logic [CW-1:0]        sb_ch0_r;

  assign sb_p0_nxt = sa_ch0_r * sa_ca_r;
  assign sb_p1_nxt = sa_ch1_r * sa_cb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_flags_r.valid <= 1'b0;
    end else if (adv) begin
      sb_flags_r.valid <= sa_flags_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_flags_r.oor <= sa_flags_r.oor;
      sb_seg_r       <= sa_seg_r;
      sb_rom_r       <= pow_rom[sa_idx_r];
      sb_p0_r        <= sb_p0_nxt;
      sb_p1_r        <= sb_p1_nxt;
      sb_ch0_r       <= sa_ch0_r;
    end
  end

  // segment terms; negative values go to zero
  tclc_pkg::div_flags_t sc_flags_r;
  tclc_pkg::seg_t       sc_seg_r;
  logic [27:0]          sc_t_r;
  logic [27:0]          sc_t_nxt;
  logic [27:0]          sc_bprod;
  logic [26:0]          sc_d_r;
  logic [26:0]          sc_d_nxt;
  logic [CW-1:0]        sc_ch0_r;

  always_comb begin
    sc_bprod = tclc_pkg::COEF_B1 * sb_rom_r;
    sc_t_nxt = (SEG1_BASE > sc_bprod) ? SEG1_BASE - sc_bprod : '0;
    sc_d_nxt = (sb_p0_r > sb_p1_r) ? sb_p0_r - sb_p1_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_flags_r.valid <= 1'b0;
    end else if (adv) begin
      sc_flags_r.valid <= sb_flags_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_flags_r.oor <= sb_flags_r.oor;
      sc_seg_r       <= sb_seg_r;
      sc_t_r         <= sc_t_nxt;
      sc_d_r         <= sc_d_nxt;
      sc_ch0_r       <= sb_ch0_r;
    end
  end

  // accumulator in Q32
  tclc_pkg::div_flags_t sd_flags_r;
  logic [AW-1:0]        sd_acc_r;
  logic [AW-1:0]        sd_acc_nxt;
  logic [AW-1:0]        sd_mul;

  always_comb begin
    sd_mul     = sc_ch0_r * sc_t_r;
    sd_acc_nxt = (sc_seg_r == tclc_pkg::SEG_POW) ? sd_mul : {1'b0, sc_d_r, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_flags_r.valid <= 1'b0;
    end else if (adv) begin
      sd_flags_r.valid <= sc_flags_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_flags_r.oor <= sc_flags_r.oor;
      sd_acc_r       <= sd_acc_nxt;
    end
  end

  // round half up, zero when out of range, clamp, output register
  logic [AW:0] rnd;
  logic [AW:0] lux_nxt;
  logic        clamp_nxt;
  logic        out_valid_r;
  logic [17:0] out_lux_r;
  logic        out_clamp_r;
  logic        out_oor_r;

  always_comb begin
    rnd       = ({1'b0, sd_acc_r} + RND_HALF) >> SH;
    lux_nxt   = rnd;
    clamp_nxt = 1'b0;
    if (sd_flags_r.oor) begin
      lux_nxt = '0;
    end else if (rnd > LUX_LIMIT) begin
      lux_nxt   = LUX_CLAMP;
      clamp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sd_flags_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lux_r   <= lux_nxt[17:0];
      out_clamp_r <= clamp_nxt;
      out_oor_r   <= sd_flags_r.oor;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_lux_value          = out_lux_r;
  assign out_was_clamped        = out_clamp_r;
  assign out_ratio_out_of_range = out_oor_r;

endmodule

### tb/tb_two_channel_lux_calc.sv
`timescale 1ns / 100ps

module tb_two_channel_lux_calc;

  localparam int RFRAC = 12;
  localparam int LFRAC = 8;
  localparam int DEPTH = 256;

  localparam int RANDOM_ITEMS = 1830;
  localparam int QUIET_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 30;

  // Q16 coefficients, round half up
  localparam longint SEG1_BB = (3040 * 65536 + 50000) / 100000;
  localparam longint SEG1_IR = (6200 * 65536 + 50000) / 100000;
  localparam longint SEG2_BB = (2240 * 65536 + 50000) / 100000;
  localparam longint SEG2_IR = (3100 * 65536 + 50000) / 100000;
  localparam longint SEG3_BB = (1280 * 65536 + 50000) / 100000;
  localparam longint SEG3_IR = (1530 * 65536 + 50000) / 100000;
  localparam longint SEG4_BB = (146 * 65536 + 50000) / 100000;
  localparam longint SEG4_IR = (112 * 65536 + 50000) / 100000;

  localparam longint unsigned THR_HALF = 64'd1 << (RFRAC - 1);
  localparam longint unsigned THR_061  = ((64'd61 << RFRAC) + 64'd50) / 64'd100;
  localparam longint unsigned THR_080  = ((64'd80 << RFRAC) + 64'd50) / 64'd100;
  localparam longint unsigned THR_130  = ((64'd130 << RFRAC) + 64'd50) / 64'd100;

  localparam longint unsigned LUX_LIMIT = 64'd1000 << LFRAC;
  localparam logic [17:0]     LUX_HELD  = 18'(999 << LFRAC);

  typedef struct packed {
    logic [17:0] lux;
    logic        clamped;
    logic        oor;
  } lux_result_t;

  typedef struct packed {
    logic [15:0] bb;
    logic [15:0] ir;
    logic        typed;
    logic [17:0] lux;
    logic        clamped;
    logic        oor;
  } stim_row_t;

  localparam int N_ROWS = 24;

  // rows marked typed carry a hand-written result, the rest go through predict_lux
  stim_row_t directed_rows [N_ROWS] = '{
    '{16'd0,     16'd0,     1'b1, 18'd0,      1'b0, 1'b1},
    '{16'd0,     16'd65535, 1'b1, 18'd0,      1'b0, 1'b1},
    '{16'd0,     16'd1,     1'b1, 18'd0,      1'b0, 1'b1},
    '{16'd1,     16'd65535, 1'b1, 18'd0,      1'b0, 1'b1},
    '{16'd65535, 16'd0,     1'b1, 18'd255744, 1'b1, 1'b0},
    '{16'd65535, 16'd65535, 1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd1,     16'd0,     1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd1,     16'd1,     1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd4096,  16'd2048,  1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd4096,  16'd2049,  1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd4096,  16'd2499,  1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd4096,  16'd2500,  1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd4096,  16'd3277,  1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd4096,  16'd3278,  1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd4096,  16'd5325,  1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd4096,  16'd5326,  1'b1, 18'd0,      1'b0, 1'b1},
    '{16'd40000, 16'd0,     1'b1, 18'd255744, 1'b1, 1'b0},
    '{16'd32768, 16'd32768, 1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd65535, 16'd32767, 1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd65535, 16'd52428, 1'b0, 18'd0,      1'b0, 1'b0},
    '{16'hAAAA,  16'h5555,  1'b0, 18'd0,      1'b0, 1'b0},
    '{16'h5555,  16'h2AAA,  1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd32896, 16'd0,     1'b0, 18'd0,      1'b0, 1'b0},
    '{16'd32912, 16'd0,     1'b0, 18'd0,      1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_broadband_count = '0;
  logic [15:0] in_infrared_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [17:0] out_lux_value;
  logic        out_was_clamped;
  logic        out_ratio_out_of_range;

  longint unsigned pow14_rom [0:DEPTH];
  lux_result_t     lux_expected [$];
  int              fail_count = 0;
  int              cycle_count = 0;
  int              gap_rate = 0;
  bit              quiet = 1'b0;

  two_channel_lux_calc #(
    .RATIO_FRAC_BITS(RFRAC),
    .LUX_FRAC_BITS  (LFRAC),
    .POW_TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_broadband_count    (in_broadband_count),
    .in_infrared_count     (in_infrared_count),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_lux_value         (out_lux_value),
    .out_was_clamped       (out_was_clamped),
    .out_ratio_out_of_range(out_ratio_out_of_range)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // exact test of v <= 2^16 * (k / 2D)^1.4 in integers: v^5 * (2D)^7 <= 2^80 * k^7
  function automatic bit pow_le(input longint unsigned v, input longint unsigned k);
    logic [191:0] lhs;
    logic [191:0] rhs;
    lhs = 192'd1;
    rhs = 192'd1 << 80;
    for (int j = 0; j < 5; j++) begin
      lhs = lhs * 192'(v);
    end
    for (int j = 0; j < 7; j++) begin
      lhs = lhs * 192'(2 * DEPTH);
      rhs = rhs * 192'(k);
    end
    return lhs <= rhs;
  endfunction

  function automatic longint unsigned round_q(input longint acc, input int sh);
    if (acc <= 0) begin
      return 0;
    end
    return (longint'(acc) + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic lux_result_t predict_lux(input logic [15:0] bb, input logic [15:0] ir);
    lux_result_t     res;
    longint unsigned ratio;
    longint unsigned lux;
    longint unsigned idx;
    longint          acc;
    res = '0;
    lux = 0;
    if (bb == 16'd0) begin
      res.oor = 1'b1;
    end else begin
      ratio = (64'(ir) << RFRAC) / 64'(bb);
      if (ratio <= THR_HALF) begin
        idx = (ratio * 2 * DEPTH) >> RFRAC;
        if (idx > DEPTH) begin
          idx = DEPTH;
        end
        acc = longint'(bb) * SEG1_BB * 65536 - longint'(bb) * SEG1_IR * longint'(pow14_rom[idx]);
        lux = round_q(acc, 32 - LFRAC);
      end else if (ratio <= THR_061) begin
        lux = round_q(longint'(bb) * SEG2_BB - longint'(ir) * SEG2_IR, 16 - LFRAC);
      end else if (ratio <= THR_080) begin
        lux = round_q(longint'(bb) * SEG3_BB - longint'(ir) * SEG3_IR, 16 - LFRAC);
      end else if (ratio <= THR_130) begin
        lux = round_q(longint'(bb) * SEG4_BB - longint'(ir) * SEG4_IR, 16 - LFRAC);
      end else begin
        res.oor = 1'b1;
      end
      if (lux > LUX_LIMIT) begin
        lux = 64'(LUX_HELD);
        res.clamped = 1'b1;
      end
    end
    res.lux = lux[17:0];
    return res;
  endfunction

  // drives at a falling edge, returns right after the accepting rising edge
  task automatic send_pair(input logic [15:0] bb, input logic [15:0] ir, input lux_result_t want);
    int gap;
    @(negedge clk);
    if (!quiet && gap_rate != 0 && $urandom_range(0, 15) < gap_rate * 3) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_broadband_count <= bb;
    in_infrared_count  <= ir;
    do begin
      @(posedge clk);
    end while (in_stall);
    lux_expected.push_back(want);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    lux_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lux_expected.size() == 0) begin
        $error("result with nothing expected: lux %0d", out_lux_value);
        fail_count++;
      end else begin
        want = lux_expected.pop_front();
        if (out_lux_value !== want.lux) begin
          $error("lux_value expected %0d actual %0d", want.lux, out_lux_value);
          fail_count++;
        end
        if (out_was_clamped !== want.clamped) begin
          $error("was_clamped expected %0d actual %0d", want.clamped, out_was_clamped);
          fail_count++;
        end
        if (out_ratio_out_of_range !== want.oor) begin
          $error("ratio_out_of_range expected %0d actual %0d", want.oor,
                 out_ratio_out_of_range);
          fail_count++;
        end
      end
    end
  end

  // result side back-pressure, rate changes now and then, zero rate gives clean stretches
  initial begin
    int burst;
    int rate;
    int slot;
    rate = 0;
    slot = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      slot++;
      if (slot % 64 == 0) begin
        rate = $urandom_range(0, 4);
      end
      if (!quiet && rate != 0 && $urandom_range(0, 15) < rate * 3) begin
        burst = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [15:0]     bb;
    logic [15:0]     ir;
    longint unsigned est;
    longint unsigned ratio;
    longint unsigned prod;
    lux_result_t     want;
    int              mode;

    // ratio^1.4 table: float estimate, then exact integer correction
    for (int k = 0; k <= DEPTH; k++) begin
      est = longint'($rtoi(65536.0 * ((real'(k) / (2.0 * DEPTH)) ** 1.4)));
      while (est > 0 && !pow_le(est, k)) begin
        est--;
      end
      while (pow_le(est + 1, k)) begin
        est++;
      end
      pow14_rom[k] = est;
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[n]) begin
      if (directed_rows[n].typed) begin
        want = '{directed_rows[n].lux, directed_rows[n].clamped, directed_rows[n].oor};
      end else begin
        want = predict_lux(directed_rows[n].bb, directed_rows[n].ir);
      end
      send_pair(directed_rows[n].bb, directed_rows[n].ir, want);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        gap_rate = $urandom_range(0, 4);
      end
      quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
      mode = $urandom_range(0, 11);
      if (mode == 0) begin
        bb = 16'd0;
        ir = 16'($urandom());
      end else if (mode <= 2) begin
        bb = 16'($urandom());
        ir = 16'($urandom());
      end else if (mode == 3) begin
        bb = 16'($urandom_range(0, 15));
        ir = 16'($urandom_range(0, 15));
      end else begin
        // well-formed pair: pick a ratio, mostly inside the segments
        bb = 16'($urandom_range(1, 65535) >> $urandom_range(0, 15));
        if (bb == 16'd0) begin
          bb = 16'd1;
        end
        if (mode >= 10) begin
          bb = bb | 16'h1000;
          case ($urandom_range(0, 3))
            0: ratio = THR_HALF;
            1: ratio = THR_061;
            2: ratio = THR_080;
            default: ratio = THR_130;
          endcase
          ratio = ratio + $urandom_range(0, 4) - 2;
        end else begin
          ratio = $urandom_range(0, 5600);
        end
        prod = (64'(bb) * ratio) >> RFRAC;
        ir = (prod > 64'hFFFF) ? 16'hFFFF : 16'(prod);
      end
      send_pair(bb, ir, predict_lux(bb, ir));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (lux_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && lux_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
